// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_POP_BACK   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_DELETE     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_r;   // push front: take left neighbor
        logic shift_l;   // pop front: take right neighbor
        logic del;       // delete: take right neighbor at and after the match
        logic load;      // push back: tail cell takes the value
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdq_in_if.sv =====
`default_nettype none
interface bdq_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bdq_out_if.sv =====
`default_nettype none
interface bdq_out_if;
    import bdq_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic        [1:0]  status;
    logic [CNT_W-1:0]   entry_count;

    modport source (output valid, output popped_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entry_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bdq_cell.sv =====
`default_nettype none
module bdq_cell
    import bdq_pkg::*;
(
    input  wire logic        clk,
    input  wire cell_ctrl_t  ctrl,
    input  wire logic [31:0] value,
    input  wire logic [31:0] left,
    input  wire logic [31:0] right,
    input  wire logic        tail,
    input  wire logic        occupied,
    input  wire logic        seen_in,
    output logic      [31:0] data,
    output logic             seen_out
);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    // match flag ripples toward the back
    assign seen_out = seen_in || (occupied && (data_reg == value));
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_r)
        begin
            data_next = left;
        end
        else if (ctrl.shift_l || (ctrl.del && seen_out))
        begin
            data_next = right;
        end
        else if (ctrl.load && tail)
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_deque_with_delete.sv =====
`default_nettype none
// bounded double-ended queue of signed 32-bit words, DEPTH entries deep.
// each request beat carries an operation (push back, pop back, push front,
// pop front, delete first match from the front) and returns exactly one
// response beat with the popped word, a status and the entry count after
// the operation. the store is a row of cells, one word each; pushes and
// pops at the front shift the whole row one place, a delete compares every
// cell at once and closes the gap behind the first match. every operation
// completes when it is accepted, so one request is taken per cycle as long as
// the response register is free or being drained. pop on empty reports
// empty, push on full is dropped and reports full, a delete with no match
// reports no match; unused operation codes do nothing and report ok.
module bounded_deque_with_delete
    import bdq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdq_in_if.sink     req,
    bdq_out_if.source  rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [31:0]      popped_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] entry_count_reg;

    logic             accept;
    logic             is_empty;
    logic             is_full;
    logic [1:0]       status_next;
    logic [31:0]      popped_next;
    cell_ctrl_t       ctrl;

    logic [DEPTH-1:0]       occupied;
    logic [DEPTH-1:0]       tail;
    logic [DEPTH-1:0]       last;
    logic [DEPTH:0]         seen;
    logic [DEPTH-1:0][31:0] data;
    logic [31:0]            back_word;

    // one response register parts the two sides
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // position decode from the count
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_pos
        localparam logic [CNT_W-1:0] POS  = CNT_W'(i);
        localparam logic [CNT_W-1:0] POS1 = CNT_W'(i + 1);
        assign occupied[i] = (POS < count_reg);
        assign tail[i]     = (POS == count_reg);
        assign last[i]     = (POS1 == count_reg);
    end

    // word at the back: only the last occupied cell contributes
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | (data[i] & {32{last[i]}});
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        popped_next = '0;
        count_next  = count_reg;
        ctrl        = '0;
        case (req.operation)
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.load  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next = back_word;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.shift_r = accept;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next  = data[0];
                    ctrl.shift_l = accept;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                // match flag leaving the last cell means some cell matched
                if (seen[DEPTH])
                begin
                    ctrl.del   = accept;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOMATCH;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // row of cells, index 0 is the front
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;

        if (i == 0)
        begin : g_front
            assign left_w = req.value;
        end
        else
        begin : g_mid_l
            assign left_w = data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_w = data[i];
        end
        else
        begin : g_mid_r
            assign right_w = data[i+1];
        end

        bdq_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .value    (req.value),
            .left     (left_w),
            .right    (right_w),
            .tail     (tail[i]),
            .occupied (occupied[i]),
            .seen_in  (seen[i]),
            .data     (data[i]),
            .seen_out (seen[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg      <= popped_next;
            status_reg      <= status_next;
            entry_count_reg <= count_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.status       = status_reg;
    assign rsp.entry_count  = entry_count_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bdq_checker.sv =====
`default_nettype none
module bdq_checker
    import bdq_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [31:0]      popped_value,
    input wire logic [1:0]       status,
    input wire logic [CNT_W-1:0] entry_count
);

    // a response beat follows every request beat
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no response after request");

    // stalled response stays up
    a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("response dropped while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (popped_value == '0))
        else $error("nonzero word with error status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with entries stored");

endmodule

bind bounded_deque_with_delete bdq_checker u_bdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .popped_value (rsp.popped_value),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count)
);
`default_nettype wire
